[rtl/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the lacing length frame splitter.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int MAX_FRAMES_DEF = 32;

  localparam logic [7:0]  LACE_CONT            = 8'hff;
  localparam logic [31:0] FRAME_DURATION_RESET = 32'd15000000;
  localparam logic        TIMESTAMPS_EN_RESET  = 1'b1;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMPS_EN  = 8'd1;

  typedef enum logic [1:0] {
    PH_START,
    PH_HEADER,
    PH_DATA,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    SQ_RUN,
    SQ_ADV,
    SQ_TRUNC
  } seq_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNCATED,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        frame_start;
    logic        frame_end;
    logic [7:0]  frame_index;
    logic [63:0] frame_timestamp;
    logic [31:0] frame_duration;
    logic        timing_valid;
    status_t     status;
    logic        last_result;
  } res_t;

endpackage

[rtl/lfs_ram.sv]
// ----------------------------------------------------------------------------
// lfs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lacing_length_frame_splitter.sv]
// ----------------------------------------------------------------------------
// lacing_length_frame_splitter
// Splits laced packet payloads into frames, one payload byte per word in,
// one frame result per word out.
// ----------------------------------------------------------------------------
// A packet's payload enters one byte per word. Header bytes build the frame
// length table, data bytes leave one result each with frame index, start and
// end marks and the frame timestamp. It takes one byte per cycle when the
// output is free; a byte that causes several results (each empty frame, and
// the truncation status that follows another result) holds the input until
// the last is out, since the sequencer writes one result per cycle into the
// output register. Lengths sit in a MAX_FRAMES deep RAM whose read address
// follows the frame counter, so the next frame's length is ready without a
// bubble. frame_timestamp is the packet timestamp plus a running product of
// frame index and duration, rebuilt by one multiply on a duration write.
// ----------------------------------------------------------------------------
module lacing_length_frame_splitter
  import lfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // payload_byte, payload_length, packet_timestamp
  input  logic [87:0]          in_tdata,
  input  logic                 in_tlast,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // data_byte, frame_index, frame_timestamp, frame_duration
  output logic [111:0]         out_tdata,
  // has_data, frame_start, timing_valid, status, last_result
  output logic [7:0]           out_tuser,
  output logic                 out_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int PROD_W = CNT_W + 32;

  function automatic logic [7:0] idx8(input logic [CNT_W-1:0] v);
    logic [CNT_W+7:0] e;
    e = {8'd0, v};
    return e[7:0];
  endfunction

  // input register
  logic        ib_valid_r;
  logic [7:0]  ib_byte_r;
  logic [15:0] ib_len_r;
  logic [63:0] ib_ts_r;
  logic        ib_last_r;

  // packet state
  phase_t             phase_r, phase_nxt;
  seq_t               seq_r, seq_nxt;
  logic [15:0]        acc_r, acc_nxt;
  logic [16:0]        cons_r, cons_nxt;
  logic [CNT_W-1:0]   frames_r, frames_nxt;
  logic [CNT_W-1:0]   cf_r, cf_nxt;
  logic [15:0]        bl_r, bl_nxt;
  logic               pend_r, pend_nxt;
  logic [63:0]        hts_r, hts_nxt;
  logic [15:0]        hlen_r, hlen_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [31:0]        dur_r, dur_nxt;
  logic               tsen_r, tsen_nxt;
  logic               zmask_r [MAX_FRAMES];

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, res;

  // length table
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [15:0]      ram_rdata;
  logic             byp_hit_r;
  logic [15:0]      byp_data_r;
  logic [15:0]      len_eff;

  // datapath
  logic             out_free, go, emit, retire, step_frame;
  logic             e_start;
  logic [15:0]      e_acc, e_hlen;
  logic [16:0]      e_cons;
  logic [CNT_W-1:0] e_frames;
  logic [16:0]      sum_a;
  logic [17:0]      sum_c;
  logic [15:0]      acc_new;
  logic [16:0]      cons_new;
  logic             zero0;
  logic [CNT_W-1:0] cfn;
  logic             nexist, nzero;
  logic [63:0]      ts_sum;
  logic [15:0]      bl_cur, bl_dec;
  logic             fend;
  logic [PROD_W-1:0] mul_p;
  res_t             timed_res;

  lfs_ram #(
    .WIDTH(16),
    .DEPTH(MAX_FRAMES),
    .AW   (IDX_W)
  ) u_len_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign len_eff  = byp_hit_r ? byp_data_r : ram_rdata;
  assign ram_raddr = cf_nxt[IDX_W-1:0];

  assign out_free  = !out_valid_r || out_tready;
  assign go        = ib_valid_r && out_free;
  assign in_tready = !ib_valid_r || retire;
  assign cfg_ready = 1'b1;

  // header arithmetic, start of packet uses cleared counters
  assign e_start  = (phase_r == PH_START);
  assign e_acc    = e_start ? 16'd0 : acc_r;
  assign e_cons   = e_start ? 17'd0 : cons_r;
  assign e_frames = e_start ? '0 : frames_r;
  assign e_hlen   = e_start ? ib_len_r : hlen_r;
  assign sum_a    = {1'b0, e_acc} + {9'd0, ib_byte_r};
  assign acc_new  = sum_a[16] ? 16'hffff : sum_a[15:0];
  assign sum_c    = {1'b0, e_cons} + {10'd0, ib_byte_r} + 18'd1;
  assign cons_new = sum_c[17] ? 17'h1ffff : sum_c[16:0];
  assign zero0    = (e_frames == '0) ? (acc_new == 16'd0) : zmask_r[0];

  // next frame lookahead
  assign cfn    = cf_r + CNT_W'(1);
  assign nexist = (cfn < frames_r);
  assign nzero  = zmask_r[cfn[IDX_W-1:0]];

  // data phase
  assign bl_cur = pend_r ? len_eff : bl_r;
  assign bl_dec = (bl_cur != 16'd0) ? bl_cur - 16'd1 : 16'd0;
  assign fend   = (bl_dec == 16'd0);

  assign ts_sum = hts_r + {{(64-PROD_W){1'b0}}, prod_r};
  assign mul_p  = PROD_W'(cf_r) * PROD_W'(cfg_data);

  always_comb begin
    timed_res                 = '0;
    timed_res.frame_index     = idx8(cf_r);
    timed_res.timing_valid    = tsen_r;
    timed_res.frame_timestamp = tsen_r ? ts_sum : 64'd0;
    timed_res.frame_duration  = tsen_r ? dur_r : 32'd0;
  end

  always_comb begin
    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    acc_nxt    = acc_r;
    cons_nxt   = cons_r;
    frames_nxt = frames_r;
    cf_nxt     = cf_r;
    bl_nxt     = bl_r;
    pend_nxt   = pend_r;
    hts_nxt    = hts_r;
    hlen_nxt   = hlen_r;
    prod_nxt   = prod_r;
    dur_nxt    = dur_r;
    tsen_nxt   = tsen_r;
    emit       = 1'b0;
    retire     = 1'b0;
    step_frame = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = e_frames[IDX_W-1:0];
    ram_wdata  = acc_new;
    res        = '0;

    if (go) begin
      unique case (seq_r)
        SQ_RUN: begin
          unique case (phase_r)
            PH_START, PH_HEADER: begin
              if (e_start) begin
                hts_nxt  = ib_ts_r;
                hlen_nxt = ib_len_r;
                cf_nxt   = '0;
                bl_nxt   = 16'd0;
                prod_nxt = '0;
                pend_nxt = 1'b0;
              end
              phase_nxt  = PH_HEADER;
              acc_nxt    = acc_new;
              cons_nxt   = cons_new;
              frames_nxt = e_frames;
              retire     = 1'b1;
              if (ib_byte_r != LACE_CONT) begin
                if (e_frames >= CNT_W'(MAX_FRAMES)) begin
                  emit            = 1'b1;
                  res.status      = ST_OVERFLOW;
                  res.frame_index = idx8(e_frames);
                  res.last_result = 1'b1;
                  phase_nxt       = ib_last_r ? PH_START : PH_DISCARD;
                end else begin
                  ram_we     = 1'b1;
                  frames_nxt = e_frames + CNT_W'(1);
                  acc_nxt    = 16'd0;
                  if (cons_new >= {1'b0, e_hlen}) begin
                    cf_nxt = '0;
                    if (zero0) begin
                      seq_nxt = SQ_ADV;
                      retire  = 1'b0;
                    end else begin
                      phase_nxt = PH_DATA;
                      pend_nxt  = 1'b1;
                    end
                  end
                end
              end
              // truncated inside the header
              if (retire && ib_last_r && !emit) begin
                emit            = 1'b1;
                res.status      = ST_TRUNCATED;
                res.frame_index = 8'd0;
                res.last_result = 1'b1;
                phase_nxt       = PH_START;
                pend_nxt        = 1'b0;
              end
            end
            PH_DATA: begin
              emit            = 1'b1;
              res             = timed_res;
              res.data_byte   = ib_byte_r;
              res.has_data    = 1'b1;
              res.frame_start = pend_r;
              res.frame_end   = fend;
              pend_nxt        = 1'b0;
              bl_nxt          = bl_dec;
              if (fend) begin
                step_frame = 1'b1;
              end else if (ib_last_r) begin
                seq_nxt = SQ_TRUNC;
              end else begin
                res.last_result = 1'b1;
                retire          = 1'b1;
              end
            end
            PH_DISCARD: begin
              retire = 1'b1;
              if (ib_last_r) begin
                phase_nxt = PH_START;
              end
            end
          endcase
        end
        SQ_ADV: begin
          emit            = 1'b1;
          res             = timed_res;
          res.frame_start = 1'b1;
          res.frame_end   = 1'b1;
          step_frame      = 1'b1;
        end
        SQ_TRUNC: begin
          emit            = 1'b1;
          res.status      = ST_TRUNCATED;
          res.frame_index = idx8(cf_r);
          res.last_result = 1'b1;
          phase_nxt       = PH_START;
          pend_nxt        = 1'b0;
          seq_nxt         = SQ_RUN;
          retire          = 1'b1;
        end
        default: begin
          seq_nxt = SQ_RUN;
        end
      endcase

      // move on to the next frame, skipping empty ones one per cycle while the output is free
      if (step_frame) begin
        cf_nxt   = cfn;
        prod_nxt = prod_r + PROD_W'(dur_r);
        if (nexist && nzero) begin
          seq_nxt = SQ_ADV;
        end else if (nexist) begin
          phase_nxt = PH_DATA;
          pend_nxt  = 1'b1;
          if (ib_last_r) begin
            seq_nxt = SQ_TRUNC;
          end else begin
            seq_nxt         = SQ_RUN;
            res.last_result = 1'b1;
            retire          = 1'b1;
          end
        end else begin
          phase_nxt       = ib_last_r ? PH_START : PH_DISCARD;
          pend_nxt        = 1'b0;
          seq_nxt         = SQ_RUN;
          res.last_result = 1'b1;
          retire          = 1'b1;
        end
      end
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_DURATION: begin
          dur_nxt  = cfg_data;
          prod_nxt = mul_p;
        end
        CFG_TIMESTAMPS_EN: begin
          tsen_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r  <= 1'b0;
      phase_r     <= PH_START;
      seq_r       <= SQ_RUN;
      frames_r    <= '0;
      cf_r        <= '0;
      pend_r      <= 1'b0;
      prod_r      <= '0;
      dur_r       <= FRAME_DURATION_RESET;
      tsen_r      <= TIMESTAMPS_EN_RESET;
      out_valid_r <= 1'b0;
      byp_hit_r   <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ib_valid_r <= 1'b1;
      end else if (retire) begin
        ib_valid_r <= 1'b0;
      end
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      frames_r    <= frames_nxt;
      cf_r        <= cf_nxt;
      pend_r      <= pend_nxt;
      prod_r      <= prod_nxt;
      dur_r       <= dur_nxt;
      tsen_r      <= tsen_nxt;
      out_valid_r <= out_valid_nxt;
      byp_hit_r   <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ib_byte_r <= in_tdata[7:0];
      ib_len_r  <= in_tdata[23:8];
      ib_ts_r   <= in_tdata[87:24];
      ib_last_r <= in_tlast;
    end
    if (emit) begin
      out_res_r <= res;
    end
    if (ram_we) begin
      zmask_r[ram_waddr] <= (ram_wdata == 16'd0);
    end
    acc_r      <= acc_nxt;
    cons_r     <= cons_nxt;
    bl_r       <= bl_nxt;
    hts_r      <= hts_nxt;
    hlen_r     <= hlen_nxt;
    byp_data_r <= ram_wdata;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.frame_duration, out_res_r.frame_timestamp,
                       out_res_r.frame_index, out_res_r.data_byte};
  assign out_tuser  = {2'b00, out_res_r.last_result, out_res_r.status,
                       out_res_r.timing_valid, out_res_r.frame_start,
                       out_res_r.has_data};
  assign out_tlast  = out_res_r.frame_end;

`ifndef NO_ASSERTIONS
  a_pend_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (phase_r == PH_DATA))
    else $error("frame start pending outside data phase");

  a_seq_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != SQ_RUN) |-> ib_valid_r)
    else $error("sequencer busy without an input word");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    cf_r <= frames_r)
    else $error("current frame past frame count");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != ST_OK)) |->
      (!out_res_r.has_data && !out_res_r.timing_valid && !out_res_r.frame_end))
    else $error("status result carries frame data");
`endif

endmodule

[sim/tb_lacing_length_frame_splitter.sv]
// ----------------------------------------------------------------------------
// tb_lacing_length_frame_splitter
// Self-checking bench for the lacing length frame splitter.
// ----------------------------------------------------------------------------
// Payload bytes go in one word at a time. A behavioral copy of the deframer
// works out the frame words that each byte must produce, and every output word
// is checked against the oldest one still owed. A short table of hand-built
// packets comes first: reset timing, timestamp wrap, truncation, extra bytes,
// empty frames. Then come the table overflow, the 32-empty-frame burst and a
// saturating length continuation. After that, random laced packets (mostly
// well formed, some with a bad length, cut short or pure noise) run under
// four register settings and changing stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb_lacing_length_frame_splitter;
  import lfs_pkg::*;

  localparam int FRAME_SLOTS = MAX_FRAMES_DEF;
  localparam int RANDOM_WORDS = 370;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic [15:0] plen;
    logic [63:0] pts;
    logic        last;
    logic        typed;
    res_t        want;
  } lace_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [87:0]          in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [111:0]         out_tdata;
  logic [7:0]           out_tuser;
  logic                 out_tlast;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // deframer state as seen by the bench
  phase_t      lace_phase = PH_START;
  int unsigned lace_sum = 0;
  int unsigned lace_used = 0;
  logic [15:0] lace_lens [FRAME_SLOTS];
  int unsigned lace_count = 0;
  int unsigned cur_frame = 0;
  int unsigned frame_left = 0;
  logic [63:0] pkt_ts = '0;
  int unsigned pkt_len = 0;
  logic [31:0] cfg_dur = FRAME_DURATION_RESET;
  logic        cfg_stamp = TIMESTAMPS_EN_RESET;

  res_t        byte_results [$];
  res_t        frames_due [$];
  res_t        seen;
  res_t        wanted;
  logic [7:0]  pkt_bytes [$];
  int unsigned frame_lens [$];

  int          mismatches = 0;
  int          counted_words = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_left = 0;
  bit          hold_ask = 1'b0;

  lace_row_t script [15] = '{
    // one byte frame right after reset
    '{8'h01, 16'd2, 64'd0, 1'b0, 1'b0, '0},
    '{8'hff, 16'd2, 64'd0, 1'b1, 1'b1,
      '{8'hff, 1'b1, 1'b1, 1'b1, 8'd0, 64'd0, FRAME_DURATION_RESET, 1'b1, ST_OK, 1'b1}},
    // empty frame then a frame whose timestamp wraps
    '{8'h00, 16'd3, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '0},
    '{8'h01, 16'd3, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'd0, 64'hffff_ffff_ffff_ffff, FRAME_DURATION_RESET,
        1'b1, ST_OK, 1'b1}},
    '{8'h00, 16'd3, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, '0},
    // packet ends inside a length continuation
    '{8'hff, 16'hffff, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b0, 1'b0, 8'd0, 64'd0, 32'd0, 1'b0, ST_TRUNCATED, 1'b1}},
    // packet ends inside a frame
    '{8'h03, 16'd4, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0},
    '{8'ha5, 16'd4, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0},
    '{8'h5a, 16'd4, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0},
    // trailing bytes after the last frame
    '{8'h01, 16'd2, 64'h7fff_ffff_ffff_fffe, 1'b0, 1'b0, '0},
    '{8'h80, 16'd2, 64'h7fff_ffff_ffff_fffe, 1'b0, 1'b0, '0},
    '{8'h7f, 16'd2, 64'h7fff_ffff_ffff_fffe, 1'b0, 1'b0, '0},
    '{8'h00, 16'd2, 64'h7fff_ffff_ffff_fffe, 1'b1, 1'b0, '0},
    // shortest payload, a single empty frame
    '{8'h00, 16'd1, 64'd5, 1'b0, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'd0, 64'd5, FRAME_DURATION_RESET, 1'b1, ST_OK, 1'b1}},
    '{8'hff, 16'd1, 64'd5, 1'b1, 1'b0, '0}
  };

  lacing_length_frame_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic res_t frame_word(input logic [7:0] data, input logic has,
                                      input logic st, input logic en,
                                      input int unsigned idx, input status_t code,
                                      input logic timed);
    res_t r;
    logic on;
    on = timed && cfg_stamp;
    r.data_byte       = data;
    r.has_data        = has;
    r.frame_start     = st;
    r.frame_end       = en;
    r.frame_index     = idx[7:0];
    r.frame_timestamp = on ? pkt_ts + 64'(idx) * 64'(cfg_dur) : 64'd0;
    r.frame_duration  = on ? cfg_dur : 32'd0;
    r.timing_valid    = on;
    r.status          = code;
    r.last_result     = 1'b0;
    return r;
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("byte=%h has=%b st=%b en=%b idx=%0d ts=%h dur=%h tv=%b status=%0d last=%b",
                     r.data_byte, r.has_data, r.frame_start, r.frame_end, r.frame_index,
                     r.frame_timestamp, r.frame_duration, r.timing_valid, r.status,
                     r.last_result);
  endfunction

  // empty frames come out at once, then the next frame with data is armed
  task automatic arm_next_frame();
    while (cur_frame < lace_count && lace_lens[cur_frame] == 16'd0) begin
      byte_results.push_back(frame_word(8'h00, 1'b0, 1'b1, 1'b1, cur_frame, ST_OK, 1'b1));
      cur_frame++;
    end
    if (cur_frame >= lace_count) begin
      lace_phase = PH_DISCARD;
    end else begin
      frame_left = lace_lens[cur_frame];
      lace_phase = PH_DATA;
    end
  endtask

  task automatic split_payload_byte(input logic [7:0] b, input logic [15:0] plen,
                                    input logic [63:0] pts, input logic last);
    logic st;
    logic en;
    byte_results.delete();
    if (lace_phase == PH_START) begin
      pkt_len = plen;
      pkt_ts = pts;
      lace_sum = 0;
      lace_used = 0;
      lace_count = 0;
      cur_frame = 0;
      frame_left = 0;
      lace_phase = PH_HEADER;
    end
    if (lace_phase == PH_HEADER) begin
      lace_sum += b;
      if (lace_sum > 32'hffff) lace_sum = 32'hffff;
      lace_used += b + 1;
      if (lace_used > 32'h1ffff) lace_used = 32'h1ffff;
      if (b != LACE_CONT) begin
        if (lace_count >= FRAME_SLOTS) begin
          byte_results.push_back(frame_word(8'h00, 1'b0, 1'b0, 1'b0, lace_count, ST_OVERFLOW,
                                            1'b0));
          lace_phase = PH_DISCARD;
        end else begin
          lace_lens[lace_count] = lace_sum[15:0];
          lace_count++;
          lace_sum = 0;
          if (lace_used >= pkt_len) begin
            cur_frame = 0;
            arm_next_frame();
          end
        end
      end
    end else if (lace_phase == PH_DATA) begin
      st = (frame_left == lace_lens[cur_frame]);
      if (frame_left > 0) frame_left--;
      en = (frame_left == 0);
      byte_results.push_back(frame_word(b, 1'b1, st, en, cur_frame, ST_OK, 1'b1));
      if (en) begin
        cur_frame++;
        arm_next_frame();
      end
    end
    if (last) begin
      if (lace_phase == PH_HEADER || lace_phase == PH_DATA)
        byte_results.push_back(frame_word(8'h00, 1'b0, 1'b0, 1'b0, cur_frame, ST_TRUNCATED,
                                          1'b0));
      lace_phase = PH_START;
    end
    if (byte_results.size() > 0) byte_results[$].last_result = 1'b1;
  endtask

  task automatic push_word(input logic [7:0] b, input logic [15:0] plen,
                           input logic [63:0] pts, input logic last,
                           input logic typed, input res_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pts, plen, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (lace_phase != PH_DISCARD) counted_words++;
    split_payload_byte(b, plen, pts, last);
    if (typed) frames_due.push_back(want);
    else foreach (byte_results[i]) frames_due.push_back(byte_results[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    // bytes that give no word may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_DURATION) cfg_dur = val;
    else if (idx == CFG_TIMESTAMPS_EN) cfg_stamp = val[0];
    @(posedge clk);
  endtask

  // header of lacing bytes followed by random frame data
  task automatic lace_frames();
    int unsigned rest;
    pkt_bytes.delete();
    foreach (frame_lens[i]) begin
      rest = frame_lens[i];
      while (rest >= 255) begin
        pkt_bytes.push_back(LACE_CONT);
        rest -= 255;
      end
      pkt_bytes.push_back(rest[7:0]);
    end
    foreach (frame_lens[i]) repeat (frame_lens[i]) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic send_packet(input logic [15:0] plen, input int unsigned keep);
    logic [63:0] pts;
    pts = {$urandom, $urandom};
    for (int i = 0; i < keep; i++)
      push_word(pkt_bytes[i], plen, pts, i == keep - 1, 1'b0, '0);
  endtask

  task automatic send_random_packet();
    int unsigned kind;
    int unsigned pick;
    int unsigned keep;
    logic [15:0] plen;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      pkt_bytes.delete();
      repeat ($urandom_range(1, 8))
        pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? LACE_CONT : 8'($urandom));
      plen = 16'($urandom_range(1, 65535));
    end else begin
      frame_lens.delete();
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(5, 32) : $urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) frame_lens.push_back(0);
        else if (pick < 98) frame_lens.push_back($urandom_range(1, 6));
        else frame_lens.push_back($urandom_range(254, 258));
      end
      lace_frames();
      plen = 16'(pkt_bytes.size());
      if (kind >= 65) plen = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
    end
    keep = pkt_bytes.size();
    if ($urandom_range(0, 99) < 15) keep = $urandom_range(1, pkt_bytes.size());
    send_packet(plen, keep);
  endtask

  // output side: stalls, long hold-off, and the check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tdata[7:0], out_tuser[0], out_tuser[1], out_tlast, out_tdata[15:8],
               out_tdata[79:16], out_tdata[111:80], out_tuser[2], status_t'(out_tuser[4:3]),
               out_tuser[5]};
      if (frames_due.size() == 0) begin
        if (mismatches < 10) $display("word with nothing owed: %s", describe(seen));
        mismatches++;
      end else begin
        wanted = frames_due.pop_front();
        if (seen !== wanted) begin
          if (mismatches < 10) begin
            $display("mismatch: want %s", describe(wanted));
            $display("          got  %s", describe(seen));
          end
          mismatches++;
        end
      end
    end
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int base;
    send_idle = 28;
    recv_idle = 86;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r])
      push_word(script[r].pbyte, script[r].plen, script[r].pts, script[r].last,
                script[r].typed, script[r].want);

    // table overflow on the 33rd length
    pkt_bytes.delete();
    repeat (33) pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h42);
    send_packet(16'hffff, 34);

    // full table of empty frames, one header byte each
    frame_lens.delete();
    repeat (FRAME_SLOTS) frame_lens.push_back(0);
    lace_frames();
    send_packet(16'(pkt_bytes.size()), pkt_bytes.size());

    // length continuation that saturates, then cut inside the frame
    pkt_bytes.delete();
    repeat (257) pkt_bytes.push_back(LACE_CONT);
    pkt_bytes.push_back(8'h01);
    repeat (3) pkt_bytes.push_back(8'($urandom));
    send_packet(16'hffff, pkt_bytes.size());

    base = counted_words;
    for (int seg = 0; seg < 4; seg++) begin
      wait_drained();
      case (seg)
        0: begin
          write_reg(CFG_FRAME_DURATION, 32'hffff_ffff);
          write_reg(CFG_TIMESTAMPS_EN, 32'd1);
        end
        1: begin
          send_idle = 86;
          recv_idle = 28;
          write_reg(CFG_FRAME_DURATION, 32'd0);
          write_reg(CFG_TIMESTAMPS_EN, 32'd1);
        end
        2: begin
          write_reg(CFG_FRAME_DURATION, $urandom);
          write_reg(CFG_TIMESTAMPS_EN, 32'd0);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(CFG_FRAME_DURATION, $urandom_range(1000, 40_000_000));
          write_reg(CFG_TIMESTAMPS_EN, 32'd1);
          // receiver holds off while a dense packet keeps coming
          hold_ask = 1'b1;
          frame_lens = '{5, 5, 5, 5};
          lace_frames();
          send_packet(16'(pkt_bytes.size()), pkt_bytes.size());
          wait_drained();
        end
      endcase
      while (counted_words < base + RANDOM_WORDS * (seg + 1) / 4) begin
        send_random_packet();
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
